// File: rtl/int64_divide_modulo_assert.svh
// Assertion macros used by the checker file of the divider block.
// Each macro expects signals named clk and arst_n in the enclosing module.
`ifndef INT64_DIVIDE_MODULO_ASSERT_SVH
`define INT64_DIVIDE_MODULO_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define I64DM_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("divider assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define I64DM_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("divider assertion failed");

`endif

// File: rtl/i64dm_pkg.sv
// Shared constants for the pipelined integer divider.
// No dependencies; used by the top level and its checker.
`default_nettype none

package i64dm_pkg;

	// Width of the operand ports and of the quotient and remainder ports.
	localparam int unsigned FIELD_W = 64;

	// Default width of the arithmetic inside the divider.
	localparam int unsigned DATA_WIDTH_DEF = 64;

	// Operation mode codes.
	localparam logic MODE_UNSIGNED = 1'b0;
	localparam logic MODE_SIGNED   = 1'b1;

endpackage

`default_nettype wire

// File: rtl/int64_divide_modulo.sv
// Pipelined integer divider: one restoring step per stage, quotient and remainder.
// Registered path: stage 1, one register set per restoring step, then the output buffer.
// Throughput: one division per cycle unless stalled; each step stage holds one add and compare.
// A two-entry output buffer lets the pipeline keep accepting while one result waits.
// Reset (arst_n low) clears all valid bits and the output buffer count; data is not reset.
// Depends on i64dm_pkg.
`default_nettype none

module int64_divide_modulo #(
	parameter int unsigned DATA_WIDTH = i64dm_pkg::DATA_WIDTH_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         req_valid,
	output logic                              req_stall,
	input  wire logic                         mode,
	input  wire logic [i64dm_pkg::FIELD_W-1:0] dividend,
	input  wire logic [i64dm_pkg::FIELD_W-1:0] divisor,
	output logic                              rsp_valid,
	input  wire logic                         rsp_stall,
	output logic [i64dm_pkg::FIELD_W-1:0]      quotient,
	output logic [i64dm_pkg::FIELD_W-1:0]      remainder,
	output logic                              divide_by_zero
);
	import i64dm_pkg::*;

	localparam int unsigned W = DATA_WIDTH;

	// Operand preparation signals.
	logic [W-1:0] a_w;
	logic [W-1:0] b_w;
	logic         dz_w;
	logic         a_neg;
	logic         b_neg;
	logic [W-1:0] a_mag;
	logic [W:0]   b_mag;

	// Stage 1: prepared operands.
	logic         vld_s1;
	logic [W-1:0] aq_s1;
	logic [W:0]   dvs_s1;
	logic         nq_s1;
	logic         nr_s1;
	logic         dz_s1;

	// Stage 2: one register set per restoring step.
	logic         vld_s2 [W];
	logic [W-1:0] rem_s2 [W];
	logic [W-1:0] aq_s2  [W];
	logic [W:0]   dvs_s2 [W];
	logic         nq_s2  [W];
	logic         nr_s2  [W];
	logic         dz_s2  [W];

	// Inputs of each step.
	logic         src_vld [W];
	logic [W-1:0] src_rem [W];
	logic [W-1:0] src_aq  [W];
	logic [W:0]   src_dvs [W];
	logic         src_nq  [W];
	logic         src_nr  [W];
	logic         src_dz  [W];

	// Final sign correction.
	logic [W-1:0] fin_q;
	logic [W-1:0] fin_r;

	// Output buffer.
	logic [1:0]         cnt_q;
	logic [FIELD_W-1:0] quo0_q;
	logic [FIELD_W-1:0] rem0_q;
	logic               dz0_q;
	logic [FIELD_W-1:0] quo1_q;
	logic [FIELD_W-1:0] rem1_q;
	logic               dz1_q;
	logic               en;
	logic               push;
	logic               pop;

	// The pipeline moves whenever the output buffer has a free entry.
	assign en        = (cnt_q != 2'd2);
	assign req_stall = !en;

	// Magnitudes and sign flags. A zero divisor becomes 2^W so that every
	// trial subtraction fails, which leaves quotient 0 and the dividend as remainder.
	assign a_w   = dividend[W-1:0];
	assign b_w   = divisor[W-1:0];
	assign dz_w  = (b_w == '0);
	assign a_neg = (mode == MODE_SIGNED) && a_w[W-1] && !dz_w;
	assign b_neg = (mode == MODE_SIGNED) && b_w[W-1];
	assign a_mag = a_neg ? ({W{1'b0}} - a_w) : a_w;
	assign b_mag = dz_w ? {1'b1, {W{1'b0}}}
		: {1'b0, (b_neg ? ({W{1'b0}} - b_w) : b_w)};

	// Stage 1 registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			aq_s1  <= a_mag;
			dvs_s1 <= b_mag;
			nq_s1  <= (a_neg ^ b_neg) && !dz_w;
			nr_s1  <= a_neg;
			dz_s1  <= dz_w;
		end
	end

	// Restoring steps, one quotient bit per stage.
	for (genvar k = 0; k < W; k++) begin : g_step
		logic [W:0]   trial;
		logic [W+1:0] diff;
		logic         ge;

		if (k == 0) begin : g_first
			assign src_vld[k] = vld_s1;
			assign src_rem[k] = '0;
			assign src_aq[k]  = aq_s1;
			assign src_dvs[k] = dvs_s1;
			assign src_nq[k]  = nq_s1;
			assign src_nr[k]  = nr_s1;
			assign src_dz[k]  = dz_s1;
		end else begin : g_next
			assign src_vld[k] = vld_s2[k-1];
			assign src_rem[k] = rem_s2[k-1];
			assign src_aq[k]  = aq_s2[k-1];
			assign src_dvs[k] = dvs_s2[k-1];
			assign src_nq[k]  = nq_s2[k-1];
			assign src_nr[k]  = nr_s2[k-1];
			assign src_dz[k]  = dz_s2[k-1];
		end

		// Shift in the next dividend bit and try to subtract the divisor.
		assign trial = {src_rem[k], src_aq[k][W-1]};
		assign diff  = {1'b0, trial} - {1'b0, src_dvs[k]};
		assign ge    = !diff[W+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s2[k] <= 1'b0;
			end else if (en) begin
				vld_s2[k] <= src_vld[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s2[k] <= ge ? diff[W-1:0] : trial[W-1:0];
				aq_s2[k]  <= {src_aq[k][W-2:0], ge};
				dvs_s2[k] <= src_dvs[k];
				nq_s2[k]  <= src_nq[k];
				nr_s2[k]  <= src_nr[k];
				dz_s2[k]  <= src_dz[k];
			end
		end
	end

	// Apply the result signs after the last step.
	assign fin_q = nq_s2[W-1] ? ({W{1'b0}} - aq_s2[W-1]) : aq_s2[W-1];
	assign fin_r = nr_s2[W-1] ? ({W{1'b0}} - rem_s2[W-1]) : rem_s2[W-1];

	assign push = en && vld_s2[W-1];
	assign pop  = (cnt_q != 2'd0) && !rsp_stall;

	// Output buffer occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	// Output buffer data: entry 0 is the head shown on the result ports.
	always_ff @(posedge clk) begin
		if (push && ((cnt_q == 2'd0) || ((cnt_q == 2'd1) && pop))) begin
			quo0_q <= FIELD_W'(fin_q);
			rem0_q <= FIELD_W'(fin_r);
			dz0_q  <= dz_s2[W-1];
		end else if ((cnt_q == 2'd2) && pop) begin
			quo0_q <= quo1_q;
			rem0_q <= rem1_q;
			dz0_q  <= dz1_q;
		end
		if (push && (cnt_q == 2'd1) && !pop) begin
			quo1_q <= FIELD_W'(fin_q);
			rem1_q <= FIELD_W'(fin_r);
			dz1_q  <= dz_s2[W-1];
		end
	end

	assign rsp_valid      = (cnt_q != 2'd0);
	assign quotient       = quo0_q;
	assign remainder      = rem0_q;
	assign divide_by_zero = dz0_q;

endmodule

`default_nettype wire

// File: rtl/i64dm_checker.sv
// Port-level checker for the pipelined divider, bound to the top level.
// Depends on i64dm_pkg and int64_divide_modulo_assert.svh.
`default_nettype none

`include "int64_divide_modulo_assert.svh"

module i64dm_checker (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         req_valid,
	input wire logic                         req_stall,
	input wire logic                         mode,
	input wire logic [i64dm_pkg::FIELD_W-1:0] dividend,
	input wire logic [i64dm_pkg::FIELD_W-1:0] divisor,
	input wire logic                         rsp_valid,
	input wire logic                         rsp_stall,
	input wire logic [i64dm_pkg::FIELD_W-1:0] quotient,
	input wire logic [i64dm_pkg::FIELD_W-1:0] remainder,
	input wire logic                         divide_by_zero
);
	import i64dm_pkg::*;

	// A stalled result holds until its transfer.
	`I64DM_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(quotient) && $stable(remainder) && $stable(divide_by_zero))

	// The input only stalls when the output buffer is full, so a result is waiting.
	`I64DM_ASSERT_SAME(a_stall_needs_result, req_stall, rsp_valid)

	// A full buffer stays full while the output side keeps stalling.
	`I64DM_ASSERT_NEXT(a_full_stays, req_stall && rsp_stall, req_stall)

	// A zero divisor always yields a zero quotient.
	`I64DM_ASSERT_SAME(a_dz_quotient, rsp_valid && divide_by_zero, quotient == {FIELD_W{1'b0}})

endmodule

bind int64_divide_modulo i64dm_checker u_i64dm_checker (.*);

`default_nettype wire
